// ----- rtl/pfcb_pkg.sv -----
// ----------------------------------------------------------------------------
// pfcb_pkg: shared types and constants for the page framebuffer column blit
// Defines the store geometry, the command codes and the beat payload types.
// ----------------------------------------------------------------------------
package pfcb_pkg;

   // Store geometry.
   localparam int COLUMNS = 128;
   localparam int PAGES   = 8;
   localparam int ROWS    = PAGES * 8;
   localparam int COL_W   = $clog2(COLUMNS);

   // Command codes carried in the mode field.
   typedef enum logic [1:0] {
      MODE_DRAW  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_WRITE = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [6:0]  column;
      logic [5:0]  bit_row;
      logic [6:0]  field_height;
      logic [63:0] pattern;
      logic        invert;
      logic [2:0]  page;
      logic [7:0]  byte_value;
   } pfcb_req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       ignored;
   } pfcb_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the request and read its column word
      logic commit;  // write the updated word and issue the response
   } pfcb_cmd_type;

endpackage

// ----- rtl/pfcb_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfcb_ctrl: command sequencer
// Accepts one command at a time and steps it through load and commit.
// ----------------------------------------------------------------------------
module pfcb_ctrl import pfcb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output pfcb_cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_COMMIT
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      accept;

   assign accept     = start && (state_ff == S_IDLE);
   assign cmd.load   = accept;
   assign cmd.commit = (state_ff == S_COMMIT);
   assign busy       = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_COMMIT;
                  busy_ff  <= 1'b1;
               end
            end
            S_COMMIT: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

endmodule

// ----- rtl/pfcb_dp.sv -----
// ----------------------------------------------------------------------------
// pfcb_dp: column store and read-modify-write datapath
// Holds the column memory, its valid bits and the merge and response logic.
// ----------------------------------------------------------------------------
module pfcb_dp import pfcb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  pfcb_cmd_type cmd,
   input  pfcb_req_type req_data,
   output logic         rsp_valid,
   output pfcb_rsp_type rsp_data
);

   localparam int CMP_W = COL_W + 2;

   logic [ROWS-1:0]    mem [COLUMNS];
   logic [COLUMNS-1:0] valid_ff;

   pfcb_req_type    req_ff;
   logic [ROWS-1:0] rd_word_ff;
   logic            rd_valid_ff;
   logic            rsp_valid_ff;
   pfcb_rsp_type    rsp_data_ff;

   logic [COL_W-1:0] rd_idx;
   logic [COL_W-1:0] wr_idx;
   logic [63:0]      word;
   logic             col_ok;
   logic             ignored;
   logic [6:0]       height;
   logic [63:0]      fmask;
   logic [63:0]      fbits;
   logic [63:0]      fmask_sh;
   logic [63:0]      fbits_sh;
   logic [5:0]       byte_sh;
   logic [63:0]      bmask;
   logic [63:0]      new_word;
   logic [7:0]       read_byte;
   logic             wr_en;

   assign rd_idx = COL_W'(req_data.column);
   assign wr_idx = COL_W'(req_ff.column);

   // A column that was never written since reset or clear reads as zero.
   assign word = rd_valid_ff ? 64'(rd_word_ff) : 64'd0;

   assign col_ok  = CMP_W'(req_ff.column) < CMP_W'(COLUMNS);
   assign byte_sh = {req_ff.page, 3'b000};

   always_comb begin
      priority if (req_ff.mode == MODE_CLEAR) begin
         ignored = 1'b0;
      end else if (!col_ok) begin
         ignored = 1'b1;
      end else if (req_ff.mode == MODE_DRAW) begin
         ignored = 7'(req_ff.bit_row) >= 7'(ROWS);
      end else begin
         ignored = 4'(req_ff.page) >= 4'(PAGES);
      end
   end

   // Clamp the draw height, build the field mask and merged bits, form the new word and the read byte.
   always_comb begin
      height   = (req_ff.field_height > 7'd64) ? 7'd64 : req_ff.field_height;
      fmask    = height[6] ? '1 : ((64'd1 << height[5:0]) - 64'd1);
      fbits    = (req_ff.pattern & fmask) ^ (req_ff.invert ? fmask : 64'd0);
      fmask_sh = fmask << req_ff.bit_row;
      fbits_sh = fbits << req_ff.bit_row;
      bmask    = 64'hff << byte_sh;
      unique case (req_ff.mode)
         MODE_DRAW:  new_word = (word & ~fmask_sh) | fbits_sh;
         MODE_WRITE: new_word = (word & ~bmask) | (64'(req_ff.byte_value) << byte_sh);
         default:    new_word = word;
      endcase
      read_byte = (req_ff.mode == MODE_READ && !ignored) ? 8'(word >> byte_sh) : 8'd0;
   end

   assign wr_en = cmd.commit && !ignored &&
                  (req_ff.mode == MODE_DRAW || req_ff.mode == MODE_WRITE);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_word_ff <= mem[rd_idx];
      end
      if (wr_en) begin
         mem[wr_idx] <= new_word[ROWS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_data;
         rd_valid_ff <= valid_ff[rd_idx];
      end
      if (cmd.commit) begin
         rsp_data_ff.read_byte <= read_byte;
         rsp_data_ff.ignored   <= ignored;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
         if (cmd.commit && req_ff.mode == MODE_CLEAR) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/page_framebuffer_column_blit.sv -----
// ----------------------------------------------------------------------------
// page_framebuffer_column_blit: monochrome page framebuffer column engine
// Draws column fields, reads and writes page bytes and clears the store.
// ----------------------------------------------------------------------------
// The load phase captures the request and reads the column word; the commit
// phase writes the merged word back and registers the response beat. busy
// holds off a new command until the current one has committed. Clear passes
// through the same phases and only drops the per-column valid bits.
// Reset: synchronous and active high; the whole store reads as zero after it.
// The receiver cannot stall: the response strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
module page_framebuffer_column_blit import pfcb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  pfcb_req_type req_data,
   output logic         rsp_valid,
   output pfcb_rsp_type rsp_data
);

   // The controller steps each accepted command through two phases. In the
   // load phase (the acceptance edge) the datapath captures the request and
   // reads the addressed column word together with its valid bit. In the
   // commit phase it merges the command into that word, writes it back and
   // registers the response beat. Because busy drops as the response is
   // registered, the next command can be accepted while the response is shown.
   pfcb_cmd_type cmd;

   pfcb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // The datapath owns the column memory. A valid bit per column stands in
   // for the cleared contents, so reset and the clear command finish at once.
   pfcb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/pfcb_checker.sv -----
// ----------------------------------------------------------------------------
// pfcb_checker: port-level checks for the column blit
// Watches the handshake and the response timing at the top-level ports.
// ----------------------------------------------------------------------------
module pfcb_checker import pfcb_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input pfcb_rsp_type rsp_data
);

   logic accept;

   assign accept = start && !busy;

   // Every accepted command produces its response beat.
   a_rsp_timing: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("response beat missing two cycles after acceptance");

   // An accepted command raises busy for its commit phase only.
   a_busy_pulse: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy ##1 !busy)
      else $error("busy did not follow the two-cycle command sequence");

   // Responses never come back to back.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two response beats in consecutive cycles");

   // An ignored command never returns data.
   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.ignored) |-> (rsp_data.read_byte == 8'd0))
      else $error("ignored command returned a nonzero byte");

endmodule

bind page_framebuffer_column_blit pfcb_checker u_pfcb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
